[rtl/rdc_pkg.sv]
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types and codes for the range distinct symbol counter
// ----------------------------------------------------------------------------
package rdc_pkg;

   // fixed field widths of the request and response words
   localparam int CMD_W      = 2;
   localparam int SYM_FIELD_W = 8;
   localparam int POS_FIELD_W = 11;
   localparam int COUNT_W    = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [SYM_FIELD_W-1:0] symbol;
      logic [POS_FIELD_W-1:0] first_pos;
      logic [POS_FIELD_W-1:0] last_pos;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               range_error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

endpackage

[rtl/rdc_ram.sv]
// ----------------------------------------------------------------------------
// rdc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/range_distinct_symbol_counter_top.sv]
// ----------------------------------------------------------------------------
// range_distinct_symbol_counter_top
// text store with a sliding window and per-symbol counts; answers how many
// different symbols lie in a queried range
// ----------------------------------------------------------------------------
// clear and append complete in idle; busy stays low, the next word may follow
// a query moves the window one position per step; each step runs the states
// decide, fetch and update (text read, count read, count write back through
// the count ram); the answer strobe rises in the same cycle that busy falls
// a rejected range is answered in the next cycle, busy stays low
// the receiver cannot stall; synchronous reset empties text and window
// ----------------------------------------------------------------------------
module range_distinct_symbol_counter_top #(
   parameter int MAX_TEXT    = 1024,
   parameter int SYMBOL_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdc_pkg::req_type req_word,
   output logic             rsp_valid,
   output rdc_pkg::rsp_type rsp_word
);

   import rdc_pkg::*;

   // derived sizes
   localparam int POS_W = $clog2(MAX_TEXT);          // text address
   localparam int LEN_W = $clog2(MAX_TEXT + 1);      // text length, counts
   localparam int NSYM  = 1 << SYMBOL_BITS;
   localparam int TOT_W = SYMBOL_BITS + 1;           // distinct total
   localparam int CMP_W = (LEN_W > POS_FIELD_W) ? LEN_W : POS_FIELD_W;

   // control state
   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   empty_ff, empty_in;     // window holds nothing
   logic                   init_ff, init_in;       // first position still to add
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [NSYM-1:0]        cnt_vld_ff, cnt_vld_in; // count entry written since clear
   logic                   rsp_valid_ff, rsp_valid_in;

   // window and target edges, 0-based inclusive
   logic [POS_W-1:0]       wf_ff, wf_in;
   logic [POS_W-1:0]       wl_ff, wl_in;
   logic [POS_W-1:0]       lo_ff, lo_in;
   logic [POS_W-1:0]       hi_ff, hi_in;

   // per-step payload
   logic                   op_add_ff, op_add_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic                   hit_vld_ff, hit_vld_in;
   rsp_type                rsp_ff, rsp_in;

   // ram ports
   logic                   text_wr_en;
   logic [POS_W-1:0]       text_wr_addr;
   logic [POS_W-1:0]       text_rd_addr;
   logic [SYMBOL_BITS-1:0] text_rd_data;
   logic                   cnt_wr_en;
   logic [LEN_W-1:0]       cnt_wr_data;
   logic [LEN_W-1:0]       cnt_rd_data;

   // decode of the incoming word
   logic                   accept;
   logic [CMP_W-1:0]       first_x, last_x;
   logic                   bad_range;
   logic                   text_full;

   // step selection in the decide state
   logic                   step_go;
   logic                   step_add;
   logic [POS_W-1:0]       step_pos;

   // current count of the symbol under update
   logic [LEN_W-1:0]       cnt_cur;

   assign accept    = start && (state_ff == ST_IDLE);
   assign first_x   = CMP_W'(req_word.first_pos);
   assign last_x    = CMP_W'(req_word.last_pos);
   assign bad_range = (first_x == '0) || (first_x > last_x) || (last_x > CMP_W'(len_ff));
   assign text_full = (len_ff >= LEN_W'(MAX_TEXT));
   assign cnt_cur   = hit_vld_ff ? cnt_rd_data : '0;

   // pick the next window move: grow left, grow right, shrink left, shrink right
   always_comb begin
      step_go  = 1'b1;
      step_add = 1'b1;
      step_pos = wl_ff;
      wf_in    = wf_ff;
      wl_in    = wl_ff;
      if (init_ff) begin
         // window was empty: it starts as the single first position
         step_pos = wl_ff;
      end else if (wf_ff > lo_ff) begin
         wf_in    = wf_ff - POS_W'(1);
         step_pos = wf_ff - POS_W'(1);
      end else if (wl_ff < hi_ff) begin
         wl_in    = wl_ff + POS_W'(1);
         step_pos = wl_ff + POS_W'(1);
      end else if (wf_ff < lo_ff) begin
         step_add = 1'b0;
         step_pos = wf_ff;
         wf_in    = wf_ff + POS_W'(1);
      end else if (wl_ff > hi_ff) begin
         step_add = 1'b0;
         step_pos = wl_ff;
         wl_in    = wl_ff - POS_W'(1);
      end else begin
         step_go  = 1'b0;
      end
      if (state_ff != ST_DECIDE) begin
         wf_in = wf_ff;
         wl_in = wl_ff;
      end
      if (accept && (req_word.command == CMD_QUERY) && !bad_range && empty_ff) begin
         // empty window: both edges start at the range's first position
         wf_in = POS_W'(first_x - CMP_W'(1));
         wl_in = POS_W'(first_x - CMP_W'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.command == CMD_QUERY) && !bad_range) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = step_go ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DECIDE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and ram controls
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      text_wr_en   = accept && (req_word.command == CMD_APPEND) && !text_full;
      text_wr_addr = POS_W'(len_ff);
      text_rd_addr = step_pos;
      cnt_wr_en    = 1'b0;
      cnt_wr_data  = cnt_cur + LEN_W'(1);
      case (state_ff)
         ST_UPDATE: begin
            if (op_add_ff) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_data = cnt_cur + LEN_W'(1);
            end else begin
               // decrement of a zero count is skipped
               cnt_wr_en   = (cnt_cur != '0);
               cnt_wr_data = cnt_cur - LEN_W'(1);
            end
         end
         default: begin
            cnt_wr_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      len_in       = len_ff;
      empty_in     = empty_ff;
      init_in      = init_ff;
      total_in     = total_ff;
      cnt_vld_in   = cnt_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      op_add_in    = op_add_ff;
      sym_in       = sym_ff;
      hit_vld_in   = hit_vld_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.command)
                  CMD_CLEAR: begin
                     len_in     = '0;
                     empty_in   = 1'b1;
                     init_in    = 1'b0;
                     total_in   = '0;
                     cnt_vld_in = '0;
                  end
                  CMD_APPEND: begin
                     if (!text_full) begin
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  CMD_QUERY: begin
                     if (bad_range) begin
                        rsp_valid_in          = 1'b1;
                        rsp_in.distinct_count = '0;
                        rsp_in.range_error    = 1'b1;
                     end else begin
                        lo_in    = POS_W'(first_x - CMP_W'(1));
                        hi_in    = POS_W'(last_x - CMP_W'(1));
                        init_in  = empty_ff;
                        empty_in = 1'b0;
                     end
                  end
                  default: begin
                     // unused command code, word is dropped
                     len_in = len_ff;
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            if (step_go) begin
               op_add_in = step_add;
               init_in   = 1'b0;
            end else begin
               rsp_valid_in          = 1'b1;
               rsp_in.distinct_count = COUNT_W'(total_ff);
               rsp_in.range_error    = 1'b0;
            end
         end
         ST_FETCH: begin
            // text symbol is back, count read is issued on it
            sym_in     = text_rd_data;
            hit_vld_in = cnt_vld_ff[text_rd_data];
         end
         ST_UPDATE: begin
            // entry counts as written only once the ram really takes it
            if (cnt_wr_en) begin
               cnt_vld_in[sym_ff] = 1'b1;
            end
            if (op_add_ff) begin
               if (cnt_cur == '0) begin
                  total_in = total_ff + TOT_W'(1);
               end
            end else if ((cnt_cur == LEN_W'(1)) && (total_ff != '0)) begin
               total_in = total_ff - TOT_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         empty_ff     <= 1'b1;
         init_ff      <= 1'b0;
         total_ff     <= '0;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         wf_ff        <= '0;
         wl_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         empty_ff     <= empty_in;
         init_ff      <= init_in;
         total_ff     <= total_in;
         cnt_vld_ff   <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         wf_ff        <= wf_in;
         wl_ff        <= wl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      op_add_ff  <= op_add_in;
      sym_ff     <= sym_in;
      hit_vld_ff <= hit_vld_in;
      rsp_ff     <= rsp_in;
   end

   // text symbols
   rdc_ram #(
      .WIDTH (SYMBOL_BITS),
      .DEPTH (MAX_TEXT)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (text_wr_addr),
      .wr_data (req_word.symbol[SYMBOL_BITS-1:0]),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   // occurrence count per symbol, unwritten entries masked by cnt_vld_ff
   rdc_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NSYM)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (sym_ff),
      .wr_data (cnt_wr_data),
      .rd_addr (text_rd_data),
      .rd_data (cnt_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
